// ===== rtl/cnorm_pkg.sv =====
// Shared types, constants and helpers for the column normaliser.
package cnorm_pkg;

    localparam int SampleWidth = 32;
    localparam int SumWidth    = 38;

    typedef enum logic [1:0] {
        METHOD_MINMAX  = 2'd0,
        METHOD_ZSCORE  = 2'd1,
        METHOD_DECIMAL = 2'd2,
        METHOD_UNUSED  = 2'd3
    } method_t;

    // Control from the top level's sequencer to the serial divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } div_rsp_t;

    // Saturate a signed 66-bit value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sh0_0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/cnorm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
module cnorm_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/cnorm_div.sv =====
// Bit-serial restoring divider for unsigned 64-bit operands, one quotient bit per cycle.
module cnorm_div
    import cnorm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], quo_reg[63]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[62:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = trial - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[63:0];

endmodule

// ===== rtl/cnorm_sqrt.sv =====
// Bit-serial integer square root of a 72-bit radicand, two radicand bits per cycle.
module cnorm_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [71:0] radicand,
    output logic        done,
    output logic [35:0] root
);

    logic [71:0] rad_reg, rad_next;
    logic [37:0] rem_reg, rem_next;
    logic [35:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [37:0] trial;
    logic [37:0] test;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[35:0], rad_reg[71:70]};
        test      = {root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd36;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[69:0], 2'b00};
            if (trial >= test)
            begin
                rem_next  = trial - test;
                root_next = {root_reg[34:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                root_next = {root_reg[34:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/column_normalizer_core.sv =====
// Column normaliser top level: sample store, run statistics and the output sequencer.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | start & !busy        | sample_value, is_final
//   config  | cfg_valid & cfg_ready| cfg_data (norm_method)
//   result  | out_strobe           | norm_value, end_of_column, overflowed
//
// Loading takes a beat whenever start is high and the block is not busy. After a final beat,
// each stored sample goes through the 64-step serial divider. Z-score first computes the
// mean and variance, with one pass over the samples, the 64-step divider three times and
// 36 root steps. Decimal scaling first finds the exponent one digit a cycle.
// Reset is asynchronous and needs no clearing pass. Results cannot be stalled.
module column_normalizer_core
    import cnorm_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] sample_value,
    input  logic        is_final,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic        out_strobe,
    output logic [31:0] norm_value,
    output logic        end_of_column,
    output logic        overflowed
);

    localparam int AddrWidth = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CntWidth  = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_VAR_RD,
        ST_VAR_ACC,
        ST_VAR_DIV,
        ST_VAR_WAIT,
        ST_VAR_DIV2,
        ST_VAR_WAIT2,
        ST_SQRT_WAIT,
        ST_DEC_SCAN,
        ST_OUT_RD,
        ST_OUT_DIV,
        ST_OUT_WAIT,
        ST_OUT_EMIT
    } state_t;

    state_t                state_reg;
    method_t               method_reg;
    logic [CntWidth-1:0]   count_reg;
    logic [AddrWidth-1:0]  idx_reg;
    logic signed [31:0]    min_reg, max_reg;
    logic signed [SumWidth-1:0] sum_reg;
    logic [31:0]           mag_reg;
    logic                  drop_reg;
    logic signed [32:0]    mean_reg;
    logic [71:0]           acc_reg;
    logic [13:0]           low_reg;
    logic [35:0]           sd_reg;
    logic [63:0]           scale_reg;
    logic [15:0]           ip_reg;
    logic                  neg_reg;
    logic                  zero_reg;
    logic                  strobe_reg;
    logic [31:0]           value_reg;
    logic                  eoc_reg;
    logic                  ovf_reg;
    logic                  sq_start_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     sq_done;
    logic [35:0] sq_root;

    logic                 ram_we;
    logic [AddrWidth-1:0] ram_waddr;
    logic [AddrWidth-1:0] ram_raddr;
    logic [31:0]          ram_rdata;

    logic signed [31:0]   x_in;
    logic [31:0]          x_mag;
    logic                 room;
    logic signed [33:0]   dev;
    logic [33:0]          dev_mag;
    logic [67:0]          dev_sq;
    logic signed [32:0]   diff_s;
    logic [65:0]          num_mag;
    logic signed [65:0]   res_s;
    logic [SumWidth-1:0]  sum_mag;
    logic [CntWidth-1:0]  last_idx;

    assign x_in  = sample_value;
    assign x_mag = x_in[31] ? (32'd0 - x_in) : x_in;
    assign room  = (count_reg < CntWidth'(MAX_SAMPLES));
    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = (state_reg == ST_LOAD);
    assign ram_we    = start && !busy && room;
    assign ram_waddr = count_reg[AddrWidth-1:0];
    assign ram_raddr = idx_reg;
    assign last_idx  = count_reg - CntWidth'(1);
    assign dev       = $signed({ram_rdata[31], ram_rdata[31], ram_rdata}) -
                       $signed({mean_reg[32], mean_reg});
    assign dev_mag   = dev[33] ? (34'd0 - dev) : dev;
    assign dev_sq    = dev_mag * dev_mag;
    assign diff_s    = $signed({ram_rdata[31], ram_rdata}) - $signed({min_reg[31], min_reg});
    assign sum_mag   = sum_reg[SumWidth-1] ? (SumWidth'(0) - sum_reg) : sum_reg;
    assign res_s     = neg_reg ? -$signed({2'b00, div_rsp.quotient})
                               : $signed({2'b00, div_rsp.quotient});

    function automatic logic [31:0] x_abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    cnorm_ram #(
        .Width (32),
        .Depth (1 << AddrWidth)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (sample_value),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    cnorm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cnorm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start_reg),
        .radicand (acc_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 64'd1;
        num_mag          = '0;
        unique case (state_reg)
            ST_MEAN_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(sum_mag);
                div_req.divisor  = 64'(count_reg);
            end
            ST_VAR_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_reg[71:8];
                div_req.divisor  = 64'(count_reg);
            end
            ST_VAR_DIV2:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(low_reg);
                div_req.divisor  = 64'(count_reg);
            end
            ST_OUT_DIV:
            begin
                div_req.start = 1'b1;
                case (method_reg)
                    METHOD_MINMAX:
                    begin
                        num_mag          = {diff_s, 16'd0, 17'd0} >> 17;
                        div_req.divisor  = {32'd0, max_reg - min_reg};
                    end
                    METHOD_ZSCORE:
                    begin
                        num_mag          = {16'd0, dev_mag, 16'd0};
                        div_req.divisor  = 64'(sd_reg);
                    end
                    default:
                    begin
                        num_mag          = 66'(x_abs32(ram_rdata));
                        div_req.divisor  = scale_reg;
                    end
                endcase
                div_req.dividend = num_mag[63:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            method_reg   <= METHOD_MINMAX;
            count_reg    <= '0;
            idx_reg      <= '0;
            min_reg      <= 32'sh7FFF_FFFF;
            max_reg      <= 32'sh8000_0000;
            sum_reg      <= '0;
            mag_reg      <= '0;
            drop_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            sq_start_reg <= 1'b0;
            eoc_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg   <= 1'b0;
            sq_start_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (cfg_valid)
                    begin
                        method_reg <= method_t'(cfg_data);
                    end
                    if (start)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CntWidth'(1);
                            if (x_in < min_reg) min_reg <= x_in;
                            if (x_in > max_reg) max_reg <= x_in;
                            sum_reg <= sum_reg + SumWidth'(x_in);
                            if (x_mag > mag_reg) mag_reg <= x_mag;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (is_final)
                        begin
                            idx_reg <= '0;
                            acc_reg <= '0;
                            if (method_reg == METHOD_ZSCORE)
                                state_reg <= ST_MEAN_DIV;
                            else if (method_reg == METHOD_DECIMAL)
                            begin
                                scale_reg <= 64'd10;
                                ip_reg    <= room ? (x_mag > mag_reg ? x_mag[31:16]
                                                                     : mag_reg[31:16])
                                                  : mag_reg[31:16];
                                state_reg <= ST_DEC_SCAN;
                            end
                            else
                                state_reg <= ST_OUT_RD;
                        end
                    end
                end
                ST_MEAN_DIV:
                begin
                    neg_reg   <= sum_reg[SumWidth-1];
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        // Negative sums round towards minus infinity.
                        if (neg_reg)
                            mean_reg <= -$signed(33'(div_rsp.quotient)) -
                                        ((div_rsp.remainder == 64'd0) ? 33'sd0 : 33'sd1);
                        else
                            mean_reg <= $signed(33'(div_rsp.quotient));
                        state_reg <= ST_VAR_RD;
                    end
                end
                ST_VAR_RD:
                begin
                    state_reg <= ST_VAR_ACC;
                end
                ST_VAR_ACC:
                begin
                    acc_reg <= acc_reg + 72'(dev_sq);
                    if (32'(idx_reg) == 32'(last_idx))
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_VAR_DIV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AddrWidth'(1);
                        state_reg <= ST_VAR_RD;
                    end
                end
                ST_VAR_DIV:
                begin
                    state_reg <= ST_VAR_WAIT;
                end
                ST_VAR_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        // The remainder and the low byte form the second dividend.
                        acc_reg   <= {div_rsp.quotient, 8'd0};
                        low_reg   <= {div_rsp.remainder[5:0], acc_reg[7:0]};
                        state_reg <= ST_VAR_DIV2;
                    end
                end
                ST_VAR_DIV2:
                begin
                    state_reg <= ST_VAR_WAIT2;
                end
                ST_VAR_WAIT2:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg      <= {acc_reg[71:8], div_rsp.quotient[7:0]};
                        sq_start_reg <= 1'b1;
                        state_reg    <= ST_SQRT_WAIT;
                    end
                end
                ST_SQRT_WAIT:
                begin
                    if (sq_done)
                    begin
                        sd_reg    <= sq_root;
                        state_reg <= ST_OUT_RD;
                    end
                end
                ST_DEC_SCAN:
                begin
                    if ({48'd0, ip_reg} >= scale_reg)
                    begin
                        scale_reg <= {scale_reg[60:0], 3'b000} + {scale_reg[62:0], 1'b0};
                    end
                    else
                        state_reg <= ST_OUT_RD;
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_DIV;
                end
                ST_OUT_DIV:
                begin
                    case (method_reg)
                        METHOD_MINMAX:
                        begin
                            neg_reg  <= 1'b0;
                            zero_reg <= !(max_reg > min_reg);
                        end
                        METHOD_ZSCORE:
                        begin
                            neg_reg  <= dev[33];
                            zero_reg <= (sd_reg == '0);
                        end
                        METHOD_DECIMAL:
                        begin
                            neg_reg  <= ram_rdata[31];
                            zero_reg <= 1'b0;
                        end
                        default:
                        begin
                            neg_reg  <= 1'b0;
                            zero_reg <= 1'b1;
                        end
                    endcase
                    state_reg <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        value_reg <= zero_reg ? 32'd0 : sat32(res_s);
                        state_reg <= ST_OUT_EMIT;
                    end
                end
                ST_OUT_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    ovf_reg    <= drop_reg;
                    if (32'(idx_reg) == 32'(last_idx))
                    begin
                        eoc_reg   <= 1'b1;
                        count_reg <= '0;
                        min_reg   <= 32'sh7FFF_FFFF;
                        max_reg   <= 32'sh8000_0000;
                        sum_reg   <= '0;
                        mag_reg   <= '0;
                        drop_reg  <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        eoc_reg   <= 1'b0;
                        idx_reg   <= idx_reg + AddrWidth'(1);
                        state_reg <= ST_OUT_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_strobe    = strobe_reg;
    assign norm_value    = value_reg;
    assign end_of_column = eoc_reg;
    assign overflowed    = ovf_reg;

    a_no_strobe_when_loading: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> $past(state_reg) == ST_OUT_EMIT)
        else $error("result strobe without an emit step");

    a_eoc_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && end_of_column) |-> !busy)
        else $error("block still busy after the last beat of a column");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntWidth'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

endmodule

// ===== sim/norm_checker.sv =====
// Checker for the column normaliser: predicts each column's results and compares them.
module norm_checker
    import cnorm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] sample_value,
    input  logic        is_final,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        out_strobe,
    input  logic [31:0] norm_value,
    input  logic        end_of_column,
    input  logic        overflowed,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 64;

    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        dropped;
    } norm_result_t;

    norm_result_t     expected_q[$];
    logic signed [31:0] column[Depth];
    int               col_count;
    longint           col_min;
    longint           col_max;
    longint           col_sum;
    longint           col_peak;
    logic             col_dropped;
    method_t          method;

    assign pending = expected_q.size();

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void clear_column();
        col_count   = 0;
        col_min     = 64'sd2147483647;
        col_max     = -64'sd2147483648;
        col_sum     = 0;
        col_peak    = 0;
        col_dropped = 1'b0;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic void take_sample(input logic [31:0] raw, input logic fin);
        longint      x;
        longint      mean;
        longint      d;
        longint      r;
        longint      scale;
        longint      ip;
        logic [127:0] acc;
        logic [127:0] variance;
        logic [127:0] cand;
        longint      root;
        norm_result_t res;
        x = longint'($signed(raw));
        if (col_count < Depth) begin
            column[col_count] = raw;
            if (x < col_min) col_min = x;
            if (x > col_max) col_max = x;
            col_sum += x;
            if ((x < 0 ? -x : x) > col_peak) col_peak = (x < 0 ? -x : x);
            col_count++;
        end else begin
            col_dropped = 1'b1;
        end
        if (!fin) return;
        mean  = 0;
        root  = 0;
        scale = 10;
        if (method == METHOD_ZSCORE) begin
            if (col_sum >= 0) mean = col_sum / col_count;
            else mean = -((-col_sum + col_count - 1) / col_count);
            acc = '0;
            for (int i = 0; i < col_count; i++) begin
                d = longint'(column[i]) - mean;
                if (d < 0) d = -d;
                acc += 128'(d) * 128'(d);
            end
            variance = acc / 128'(col_count);
            for (int b = 35; b >= 0; b--) begin
                cand = 128'(root) | (128'd1 << b);
                if (cand * cand <= variance) root = longint'(cand);
            end
        end else if (method == METHOD_DECIMAL) begin
            ip = col_peak >>> 16;
            while (ip >= 10) begin
                ip /= 10;
                scale *= 10;
            end
        end
        for (int i = 0; i < col_count; i++) begin
            x = longint'(column[i]);
            r = 0;
            case (method)
                METHOD_MINMAX:
                    if (col_max > col_min) r = ((x - col_min) * 65536) / (col_max - col_min);
                METHOD_ZSCORE:
                    if (root != 0) r = ((x - mean) * 65536) / root;
                METHOD_DECIMAL:
                    r = x / scale;
                default:
                    r = 0;
            endcase
            res.value   = clip32(r);
            res.last    = (i + 1 == col_count);
            res.dropped = col_dropped;
            expected_q.insert(expected_q.size(), res);
        end
        clear_column();
    endfunction

    always @(posedge clk or negedge rst_n) begin
        norm_result_t want;
        if (!rst_n) begin
            expected_q.delete();
            clear_column();
            method     = METHOD_MINMAX;
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                method = method_t'(cfg_data);
            end
            if (start && !busy) begin
                take_sample(sample_value, is_final);
            end
            if (out_strobe) begin
                if (expected_q.size() == 0) begin
                    report($sformatf("unexpected result %h", norm_value));
                end else begin
                    want = expected_q.pop_front();
                    if (norm_value !== want.value)
                        report($sformatf("norm_value %h, want %h", norm_value, want.value));
                    if (end_of_column !== want.last)
                        report($sformatf("end_of_column %b, want %b", end_of_column, want.last));
                    if (overflowed !== want.dropped)
                        report($sformatf("overflowed %b, want %b", overflowed, want.dropped));
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the column normaliser: stimulus, idling and the verdict.
module tb_top
    import cnorm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] sample_value = '0;
    logic        is_final = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;
    logic        out_strobe;
    logic [31:0] norm_value;
    logic        end_of_column;
    logic        overflowed;
    int          fail_count;
    int          pending;
    int          idle_pct;
    int          sent;

    always #5 clk = ~clk;

    column_normalizer_core u_top (.*);

    norm_checker u_checker (.*);

    task automatic send_sample(input logic [31:0] v, input logic fin);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start        <= 1'b1;
        sample_value <= v;
        is_final     <= fin;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    task automatic set_method(input method_t m);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
            default: return 32'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic send_column(input int len);
        for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
    endtask

    initial begin
        #20ms;
        $display("** column_normalizer_core: FAILED **");
        $finish;
    end

    initial begin
        int len;
        idle_pct = 16;
        sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int m = 0; m < 4; m++) begin
            set_method(method_t'(m));
            send_sample(32'h7FFF_FFFF, 1'b0);
            send_sample(32'h8000_0000, 1'b0);
            send_sample(32'h0000_0000, 1'b1);
            send_sample(32'h0003_0000, 1'b0);
            send_sample(32'h0003_0000, 1'b1);
            send_sample(32'h0000_8000, 1'b1);
        end
        set_method(METHOD_DECIMAL);
        for (int i = 0; i < 66; i++) send_sample(rand_sample(), i == 65);
        while (sent < 420) begin
            if (sent > 180) idle_pct = 62;
            if (sent > 300) idle_pct = 0;
            set_method(method_t'($urandom_range(3)));
            repeat ($urandom_range(1, 3)) begin
                len = ($urandom_range(15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
                send_column(len);
            end
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0) begin
            $display("** column_normalizer_core: PASSED **");
        end else begin
            $display("** column_normalizer_core: FAILED **");
        end
        $finish;
    end

endmodule
